### src/shape_pixel_coverage_defines.svh
// Assertion macros for the checker of shape_pixel_coverage.
// Depends on nothing; included by the checker file.
`ifndef SHAPE_PIXEL_COVERAGE_DEFINES_SVH
`define SHAPE_PIXEL_COVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spc assertion failed (same-cycle implication)");

// Next-cycle implication, disabled while reset is asserted.
`define SPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spc assertion failed (next-cycle implication)");

`endif

### src/spc_pkg.sv
// Package for shape_pixel_coverage: register indexes, shape codes, constants
// and the structs passed between the pipeline modules. No dependencies.
package spc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W      = 10;
    localparam int SIZE_W     = 9;
    localparam int COLOR_W    = 16;
    localparam int RSQ_W      = 19;
    localparam int OUT_W      = 24;
    localparam int RING_LIMIT = 50;
    localparam int RSQ_BIAS   = 2;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SHAPE_KIND    = 3'd0,
        REG_POS_X         = 3'd1,
        REG_POS_Y         = 3'd2,
        REG_SIZE_A        = 3'd3,
        REG_SIZE_B        = 3'd4,
        REG_FILL_COLOR    = 3'd5,
        REG_OUTLINE_COLOR = 3'd6,
        REG_FILLED        = 3'd7
    } cfg_reg_t;

    // Shape kinds; the remaining code behaves as none
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_RECT   = 2'd1;
    localparam logic [1:0] KIND_CIRCLE = 2'd2;

    // Programmed shape plus the radius-squared term derived from it
    typedef struct packed {
        logic [1:0]         kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [SIZE_W-1:0]  size_a;
        logic [SIZE_W-1:0]  size_b;
        logic [COLOR_W-1:0] fill_color;
        logic [COLOR_W-1:0] outline_color;
        logic               filled;
        logic [RSQ_W-1:0]   rsq;
    } cfg_t;

    // Rectangle tests carried from the geometry stage
    typedef struct packed {
        logic in_rect;
        logic border;
    } rect_flags_t;

endpackage

### src/spc_cfg_regs.sv
// Configuration register file for shape_pixel_coverage, including the
// registered radius-squared term. Depends on spc_pkg.
module spc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [spc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [spc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output spc_pkg::cfg_t                    cfg
);

    logic [1:0]                    kind_reg;
    logic [spc_pkg::POS_W-1:0]     pos_x_reg;
    logic [spc_pkg::POS_W-1:0]     pos_y_reg;
    logic [spc_pkg::SIZE_W-1:0]    size_a_reg;
    logic [spc_pkg::SIZE_W-1:0]    size_b_reg;
    logic [spc_pkg::COLOR_W-1:0]   fill_color_reg;
    logic [spc_pkg::COLOR_W-1:0]   outline_color_reg;
    logic                          filled_reg;
    logic [spc_pkg::RSQ_W-1:0]     rsq_reg;
    logic [spc_pkg::RSQ_W-1:0]     rsq_next;
    logic [2*spc_pkg::SIZE_W-1:0]  a_sq;

    // Radius squared minus the bias, registered so the multiply stays off the
    // pixel path
    assign a_sq     = (2*spc_pkg::SIZE_W)'(size_a_reg) * (2*spc_pkg::SIZE_W)'(size_a_reg);
    assign rsq_next = spc_pkg::RSQ_W'({1'b0, a_sq}) - spc_pkg::RSQ_W'(spc_pkg::RSQ_BIAS);

    // Register writes, values truncated to each register's width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg          <= '0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            size_a_reg        <= '0;
            size_b_reg        <= '0;
            fill_color_reg    <= '0;
            outline_color_reg <= '0;
            filled_reg        <= 1'b0;
            rsq_reg           <= spc_pkg::RSQ_W'(-spc_pkg::RSQ_BIAS);
        end
        else
        begin
            rsq_reg <= rsq_next;
            if (cfg_we)
            begin
                unique case (spc_pkg::cfg_reg_t'(cfg_addr))
                    spc_pkg::REG_SHAPE_KIND:    kind_reg          <= cfg_wdata[1:0];
                    spc_pkg::REG_POS_X:         pos_x_reg         <= cfg_wdata[spc_pkg::POS_W-1:0];
                    spc_pkg::REG_POS_Y:         pos_y_reg         <= cfg_wdata[spc_pkg::POS_W-1:0];
                    spc_pkg::REG_SIZE_A:        size_a_reg        <= cfg_wdata[spc_pkg::SIZE_W-1:0];
                    spc_pkg::REG_SIZE_B:        size_b_reg        <= cfg_wdata[spc_pkg::SIZE_W-1:0];
                    spc_pkg::REG_FILL_COLOR:    fill_color_reg    <= cfg_wdata;
                    spc_pkg::REG_OUTLINE_COLOR: outline_color_reg <= cfg_wdata;
                    spc_pkg::REG_FILLED:        filled_reg        <= cfg_wdata[0];
                    default:                    ;
                endcase
            end
        end
    end

    // Gather the registers for the pipeline
    always_comb
    begin
        cfg.kind          = kind_reg;
        cfg.pos_x         = pos_x_reg;
        cfg.pos_y         = pos_y_reg;
        cfg.size_a        = size_a_reg;
        cfg.size_b        = size_b_reg;
        cfg.fill_color    = fill_color_reg;
        cfg.outline_color = outline_color_reg;
        cfg.filled        = filled_reg;
        cfg.rsq           = rsq_reg;
    end

endmodule

### src/spc_geom.sv
// Geometry stage of shape_pixel_coverage: offsets, squares and rectangle
// bound tests, registered. Depends on spc_pkg.
module spc_geom #(
    parameter int COORD_BITS = 11
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [COORD_BITS-1:0]                x,
    input  logic [COORD_BITS-1:0]                y,
    input  spc_pkg::cfg_t                        cfg,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2*(((COORD_BITS > spc_pkg::POS_W) ? COORD_BITS : spc_pkg::POS_W) + 1)-1:0] dx_sq,
    output logic [2*(((COORD_BITS > spc_pkg::POS_W) ? COORD_BITS : spc_pkg::POS_W) + 1)-1:0] dy_sq,
    output spc_pkg::rect_flags_t                 rect
);

    // Signed width holding any coordinate, offset or rectangle edge
    localparam int DW   = ((COORD_BITS > spc_pkg::POS_W) ? COORD_BITS : spc_pkg::POS_W) + 1;
    localparam int SQ_W = 2 * DW;

    logic signed [DW-1:0]   xe;
    logic signed [DW-1:0]   ye;
    logic signed [DW-1:0]   pxe;
    logic signed [DW-1:0]   pye;
    logic signed [DW-1:0]   right;
    logic signed [DW-1:0]   bottom;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic signed [SQ_W-1:0] dx_prod;
    logic signed [SQ_W-1:0] dy_prod;
    spc_pkg::rect_flags_t   rect_next;

    logic                   valid_reg;
    logic [SQ_W-1:0]        dx_sq_reg;
    logic [SQ_W-1:0]        dy_sq_reg;
    spc_pkg::rect_flags_t   rect_reg;

    // Sign-extend coordinates and position, form the far edges
    assign xe     = {{(DW-COORD_BITS){x[COORD_BITS-1]}}, x};
    assign ye     = {{(DW-COORD_BITS){y[COORD_BITS-1]}}, y};
    assign pxe    = {{(DW-spc_pkg::POS_W){cfg.pos_x[spc_pkg::POS_W-1]}}, cfg.pos_x};
    assign pye    = {{(DW-spc_pkg::POS_W){cfg.pos_y[spc_pkg::POS_W-1]}}, cfg.pos_y};
    assign right  = pxe + $signed({{(DW-spc_pkg::SIZE_W){1'b0}}, cfg.size_a});
    assign bottom = pye + $signed({{(DW-spc_pkg::SIZE_W){1'b0}}, cfg.size_b});

    // Offsets from the circle centre and their squares
    assign dx      = xe - pxe;
    assign dy      = ye - pye;
    assign dx_prod = dx * dx;
    assign dy_prod = dy * dy;

    // Rectangle containment and border rows and columns
    always_comb
    begin
        rect_next.in_rect = (xe >= pxe) && (xe < right) && (ye >= pye) && (ye < bottom);
        rect_next.border  = (xe == pxe) || (ye == pye) ||
                            (xe == right - DW'(1)) || (ye == bottom - DW'(1));
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload registers load only with a new request
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            dx_sq_reg <= dx_prod;
            dy_sq_reg <= dy_prod;
            rect_reg  <= rect_next;
        end
    end

    assign out_valid = valid_reg;
    assign dx_sq     = dx_sq_reg;
    assign dy_sq     = dy_sq_reg;
    assign rect      = rect_reg;

endmodule

### src/spc_resolve.sv
// Resolve stage of shape_pixel_coverage: circle distance test, colour
// selection and the result register. Depends on spc_pkg.
module spc_resolve #(
    parameter int COORD_BITS = 11
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2*(((COORD_BITS > spc_pkg::POS_W) ? COORD_BITS : spc_pkg::POS_W) + 1)-1:0] dx_sq,
    input  logic [2*(((COORD_BITS > spc_pkg::POS_W) ? COORD_BITS : spc_pkg::POS_W) + 1)-1:0] dy_sq,
    input  spc_pkg::rect_flags_t                 rect,
    input  spc_pkg::cfg_t                        cfg,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 covered,
    output logic [spc_pkg::COLOR_W-1:0]          color
);

    localparam int DW   = ((COORD_BITS > spc_pkg::POS_W) ? COORD_BITS : spc_pkg::POS_W) + 1;
    localparam int SQ_W = 2 * DW;
    localparam int SW   = SQ_W + 2;

    logic [SQ_W:0]                dist_sum;
    logic signed [SW-1:0]         rsq_e;
    logic signed [SW-1:0]         diff;
    logic                         circ_inside;
    logic                         circ_ring;
    logic                         has_outline;
    logic                         cov_next;
    logic [spc_pkg::COLOR_W-1:0]  color_next;

    logic                         valid_reg;
    logic                         covered_reg;
    logic [spc_pkg::COLOR_W-1:0]  color_reg;

    // Squared distance against radius squared; the difference gives both tests
    assign dist_sum    = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign rsq_e       = {{(SW-spc_pkg::RSQ_W){cfg.rsq[spc_pkg::RSQ_W-1]}}, cfg.rsq};
    assign diff        = rsq_e - $signed({1'b0, dist_sum});
    assign circ_inside = !diff[SW-1];
    assign circ_ring   = diff < $signed(SW'(spc_pkg::RING_LIMIT));

    // An outline exists when its colour is set or the interior is empty
    assign has_outline = (cfg.outline_color != '0) || !cfg.filled;

    // Colour selection by shape kind
    always_comb
    begin
        cov_next   = 1'b0;
        color_next = '0;
        case (cfg.kind)
            spc_pkg::KIND_RECT:
            begin
                if (rect.in_rect)
                begin
                    if (has_outline && rect.border)
                    begin
                        cov_next   = 1'b1;
                        color_next = cfg.outline_color;
                    end
                    else if (cfg.filled)
                    begin
                        cov_next   = 1'b1;
                        color_next = cfg.fill_color;
                    end
                end
            end
            spc_pkg::KIND_CIRCLE:
            begin
                if (circ_inside)
                begin
                    if (has_outline && circ_ring)
                    begin
                        cov_next   = 1'b1;
                        color_next = cfg.outline_color;
                    end
                    else if (cfg.filled)
                    begin
                        cov_next   = 1'b1;
                        color_next = cfg.fill_color;
                    end
                end
            end
            default:
            begin
                cov_next   = 1'b0;
                color_next = '0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Result register holds while the downstream side stalls
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            covered_reg <= cov_next;
            color_reg   <= color_next;
        end
    end

    assign out_valid = valid_reg;
    assign covered   = covered_reg;
    assign color     = color_reg;

endmodule

### src/shape_pixel_coverage.sv
// Path: a request accepted into the input register passes through the geometry
// and result registers before its result appears on m_tdata.
// Throughput: one pixel per cycle while m_tready is high; each of the three
// register stages takes a request when empty, so bubbles close up.
// Reset: rst_n clears all stage valid bits, zeroes the shape registers, rsq = -RSQ_BIAS.
module shape_pixel_coverage #(
    parameter int COORD_BITS = 11
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port
    input  logic                                  cfg_we,
    input  logic [spc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [spc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // Pixel requests
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,  // pixel_x, pixel_y, zero pad
    // Coverage results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [spc_pkg::OUT_W-1:0]             m_tdata   // covered, pixel_color, zero pad
);

    localparam int DW   = ((COORD_BITS > spc_pkg::POS_W) ? COORD_BITS : spc_pkg::POS_W) + 1;
    localparam int SQ_W = 2 * DW;

    spc_pkg::cfg_t               cfg;
    logic                        in_valid_reg;
    logic [COORD_BITS-1:0]       x_reg;
    logic [COORD_BITS-1:0]       y_reg;
    logic                        geom_ready;
    logic                        geom_valid;
    logic                        res_ready;
    logic [SQ_W-1:0]             dx_sq;
    logic [SQ_W-1:0]             dy_sq;
    spc_pkg::rect_flags_t        rect;
    logic                        covered;
    logic [spc_pkg::COLOR_W-1:0] pixel_color;

    spc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Input register
    assign s_tready = !in_valid_reg || geom_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            x_reg <= s_tdata[COORD_BITS-1:0];
            y_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
        end
    end

    spc_geom #(
        .COORD_BITS (COORD_BITS)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (geom_ready),
        .x         (x_reg),
        .y         (y_reg),
        .cfg       (cfg),
        .out_valid (geom_valid),
        .out_ready (res_ready),
        .dx_sq     (dx_sq),
        .dy_sq     (dy_sq),
        .rect      (rect)
    );

    spc_resolve #(
        .COORD_BITS (COORD_BITS)
    ) u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_ready  (res_ready),
        .dx_sq     (dx_sq),
        .dy_sq     (dy_sq),
        .rect      (rect),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .covered   (covered),
        .color     (pixel_color)
    );

    // Pack the result, covered in the lowest bit
    assign m_tdata = {(spc_pkg::OUT_W - spc_pkg::COLOR_W - 1)'(0), pixel_color, covered};

endmodule

### src/spc_checker.sv
// Port-level checker for shape_pixel_coverage and its bind to the top level.
// Depends on spc_pkg and shape_pixel_coverage_defines.svh.
`include "shape_pixel_coverage_defines.svh"

module spc_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [spc_pkg::OUT_W-1:0]             m_tdata
);

    // A pixel that is not covered carries a zero colour
    `SPC_ASSERT_IMPL(a_uncovered_zero, clk, rst_n, m_tvalid && !m_tdata[0],
        m_tdata[spc_pkg::COLOR_W:1] == '0)

    // A stalled result keeps its payload
    `SPC_ASSERT_NEXT(a_stall_holds, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // With the output draining, the whole pipeline can take a request
    `SPC_ASSERT_IMPL(a_ready_when_draining, clk, rst_n, m_tready, s_tready)

    // A request reaches the output when m_tready holds while it passes the geometry and result registers
    `SPC_ASSERT_NEXT(a_latency, clk, rst_n,
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready, m_tvalid)

endmodule

bind shape_pixel_coverage spc_checker u_spc_checker (.*);
